[rtl/mhla_pkg.sv]
// ----------------------------------------------------------------------------
// mhla_pkg
// Shared types and constants of the median level alarm: beat layouts,
// register indexes, level codes and the control bundles of the cell ring.
// ----------------------------------------------------------------------------
package mhla_pkg;

    localparam int WINDOW  = 9;
    localparam int DIST_W  = 13;
    localparam int MARGIN_W = 10;
    localparam int CONF_W  = 4;
    localparam int LVL_W   = 2;
    localparam int TOTAL_W = 32;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int STEP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = DIST_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DANGER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID = 3'd5;

    // level codes
    localparam logic [LVL_W-1:0] LVL_NORMAL    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_DANGER    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_EMERGENCY = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [DIST_W-1:0] distance;
    } in_beat_t;

    typedef struct packed {
        logic [LVL_W-1:0]   level;
        logic [DIST_W-1:0]  smoothed;
        logic               rejected;
        logic               level_changed;
        logic [TOTAL_W-1:0] rejected_total;
        logic [TOTAL_W-1:0] accepted_total;
    } out_beat_t;

    // control of one ring cell
    typedef struct packed {
        logic shift_en;   // new sample enters at the head
        logic rot_en;     // ring turns by one place
        logic tag_load;   // occupancy tags are set up for a scan
    } cell_ctrl_t;

    // debounce state of the level tracker
    typedef struct packed {
        logic [LVL_W-1:0]  stable;
        logic [LVL_W-1:0]  cand;
        logic [CONF_W-1:0] run;
    } lvl_state_t;

    typedef struct packed {
        lvl_state_t nxt;
        logic       changed;
    } lvl_update_t;

endpackage

[rtl/mhla_cell.sv]
// ----------------------------------------------------------------------------
// mhla_cell
// One window entry of the sample ring: holds a distance and an occupancy tag,
// passes both to its neighbor and compares its entry with the broadcast
// candidate during the median scan.
// ----------------------------------------------------------------------------
module mhla_cell import mhla_pkg::*; (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DIST_W-1:0] data_in,
    input  logic              tag_in,
    input  logic              tag_init,
    input  logic [DIST_W-1:0] probe,
    output logic [DIST_W-1:0] data_out,
    output logic              tag_out,
    output logic              below,
    output logic              not_above
);

    logic [DIST_W-1:0] data_reg;
    logic              tag_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en || ctrl.rot_en) begin
            data_reg <= data_in;
        end
        if (ctrl.tag_load) begin
            tag_reg <= tag_init;
        end else if (ctrl.rot_en) begin
            tag_reg <= tag_in;
        end
    end

    assign data_out  = data_reg;
    assign tag_out   = tag_reg;
    assign below     = tag_reg && (data_reg < probe);
    assign not_above = tag_reg && (data_reg <= probe);

endmodule

[rtl/mhla_level.sv]
// ----------------------------------------------------------------------------
// mhla_level
// Level classifier with hysteresis and the confirm run that debounces the
// stable level.
// ----------------------------------------------------------------------------
module mhla_level import mhla_pkg::*; (
    input  logic [DIST_W-1:0]   median,
    input  lvl_state_t          cur,
    input  logic [DIST_W-1:0]   danger_th,
    input  logic [DIST_W-1:0]   emergency_th,
    input  logic [MARGIN_W-1:0] margin,
    input  logic [CONF_W-1:0]   confirm,
    output lvl_update_t         upd
);

    logic [DIST_W:0]    dang_out;
    logic [DIST_W:0]    emer_out;
    logic [DIST_W:0]    med_ext;
    logic [LVL_W-1:0]   cls;
    logic [CONF_W-1:0]  run_inc;

    assign dang_out = {1'b0, danger_th} + (DIST_W+1)'(margin);
    assign emer_out = {1'b0, emergency_th} + (DIST_W+1)'(margin);
    assign med_ext  = {1'b0, median};
    assign run_inc  = cur.run + 1'b1;

    always_comb begin
        case (cur.stable)
            LVL_NORMAL: begin
                if (median <= emergency_th)   cls = LVL_EMERGENCY;
                else if (median <= danger_th) cls = LVL_DANGER;
                else                          cls = LVL_NORMAL;
            end
            LVL_DANGER: begin
                if (median <= emergency_th)   cls = LVL_EMERGENCY;
                else if (med_ext > dang_out)  cls = LVL_NORMAL;
                else                          cls = LVL_DANGER;
            end
            LVL_EMERGENCY: begin
                if (med_ext > emer_out) begin
                    cls = (med_ext > dang_out) ? LVL_NORMAL : LVL_DANGER;
                end else begin
                    cls = LVL_EMERGENCY;
                end
            end
            default: cls = cur.stable;
        endcase
    end

    always_comb begin
        upd.nxt     = cur;
        upd.changed = 1'b0;
        if (cls == cur.stable) begin
            upd.nxt.run = '0;
        end else if (cls == cur.cand) begin
            upd.nxt.run = run_inc;
            if (run_inc >= confirm) begin
                upd.nxt.stable = cls;
                upd.nxt.run    = '0;
                upd.changed    = 1'b1;
            end
        end else begin
            upd.nxt.cand = cls;
            upd.nxt.run  = CONF_W'(1);
        end
    end

endmodule

[rtl/median_hysteresis_level_alarm_core.sv]
// ----------------------------------------------------------------------------
// median_hysteresis_level_alarm_core
// Running median of distance samples with a debounced, hysteresis based
// three level alarm.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A sample that lands in the window (or a
// rejected one while the window holds entries) passes through the scan state
// and then the finish state, which loads its result; only then can the next
// beat be accepted. The median is found by turning the ring of window cells
// once, one candidate entry per cycle, with every cell comparing itself
// against it. A clear command, or a rejected sample with an empty window,
// goes from accept straight to the finish state. The result sits in an output
// register, so the next beat is accepted while the previous result still
// waits; that next beat then holds in the finish state until the previous
// result is taken. Configuration writes take effect at once and are meant for
// idle periods only.
// ----------------------------------------------------------------------------
module median_hysteresis_level_alarm_core import mhla_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t              state_reg;
    logic [DIST_W-1:0]   danger_reg, emergency_reg, min_valid_reg, max_valid_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [CONF_W-1:0]   confirm_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [STEP_W-1:0]   step_reg;
    lvl_state_t          lvl_reg;
    logic [TOTAL_W-1:0]  rej_total_reg, acc_total_reg;
    logic [DIST_W-1:0]   smooth_reg;
    logic                rejected_reg;
    logic                track_reg;     // level update due at finish
    logic                m_valid_reg;
    out_beat_t           m_data_reg;

    logic                s_fire, out_free, out_load, is_sample, is_reject;
    logic [CNT_W-1:0]    fill_next, half, lt_cnt, le_cnt;
    logic [DIST_W-1:0]   head_in, probe;
    logic                probe_tag, hit;
    cell_ctrl_t          cctrl;
    logic [DIST_W-1:0]   cell_data [WINDOW];
    logic [WINDOW-1:0]   cell_tag, lt_vec, le_vec;
    lvl_update_t         upd;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_FINISH) && out_free;
    assign is_reject = !s_data.mode &&
                       ((s_data.distance < min_valid_reg) || (s_data.distance > max_valid_reg));
    assign is_sample = !s_data.mode && !is_reject;

    always_comb begin
        fill_next = fill_reg;
        if (is_sample && (fill_reg < CNT_W'(WINDOW))) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign cctrl.shift_en = s_fire && is_sample;
    assign cctrl.rot_en   = (state_reg == ST_SCAN);
    assign cctrl.tag_load = s_fire;
    assign head_in = cctrl.shift_en ? s_data.distance : cell_data[WINDOW-1];

    // ring of window cells, head at cell 0
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        mhla_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cctrl),
            .data_in   ((i == 0) ? head_in : cell_data[(i == 0) ? 0 : i-1]),
            .tag_in    (cell_tag[(i == 0) ? WINDOW-1 : i-1]),
            .tag_init  (CNT_W'(i) < fill_next),
            .probe     (probe),
            .data_out  (cell_data[i]),
            .tag_out   (cell_tag[i]),
            .below     (lt_vec[i]),
            .not_above (le_vec[i])
        );
    end

    // candidate is the tail cell; it is the median when its rank straddles half
    assign probe     = cell_data[WINDOW-1];
    assign probe_tag = cell_tag[WINDOW-1];
    assign half      = fill_reg >> 1;
    assign lt_cnt    = CNT_W'($countones(lt_vec));
    assign le_cnt    = CNT_W'($countones(le_vec));
    assign hit       = probe_tag && (lt_cnt <= half) && (le_cnt > half);

    mhla_level u_level (
        .median       (smooth_reg),
        .cur          (lvl_reg),
        .danger_th    (danger_reg),
        .emergency_th (emergency_reg),
        .margin       (margin_reg),
        .confirm      (confirm_reg),
        .upd          (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            danger_reg    <= DIST_W'(1600);
            emergency_reg <= DIST_W'(1360);
            margin_reg    <= MARGIN_W'(80);
            confirm_reg   <= CONF_W'(5);
            min_valid_reg <= DIST_W'(80);
            max_valid_reg <= DIST_W'(6400);
            fill_reg      <= '0;
            step_reg      <= '0;
            lvl_reg       <= '{stable: LVL_NORMAL, cand: LVL_NORMAL, run: '0};
            rej_total_reg <= '0;
            acc_total_reg <= '0;
            track_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DANGER:    danger_reg    <= cfg_wdata;
                    REG_EMERGENCY: emergency_reg <= cfg_wdata;
                    REG_MARGIN:    margin_reg    <= cfg_wdata[MARGIN_W-1:0];
                    REG_CONFIRM:   confirm_reg   <= cfg_wdata[CONF_W-1:0];
                    REG_MIN_VALID: min_valid_reg <= cfg_wdata;
                    REG_MAX_VALID: max_valid_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // a new result loads, or a waiting one stays until taken
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        step_reg     <= '0;
                        rejected_reg <= is_reject;
                        track_reg    <= is_sample;
                        if (s_data.mode) begin
                            fill_reg      <= '0;
                            lvl_reg.cand  <= lvl_reg.stable;
                            lvl_reg.run   <= '0;
                            rej_total_reg <= '0;
                            acc_total_reg <= '0;
                            smooth_reg    <= '0;
                            state_reg     <= ST_FINISH;
                        end else if (is_reject) begin
                            rej_total_reg <= rej_total_reg + 1'b1;
                            smooth_reg    <= s_data.distance;
                            state_reg     <= (fill_reg == '0) ? ST_FINISH : ST_SCAN;
                        end else begin
                            acc_total_reg <= acc_total_reg + 1'b1;
                            fill_reg      <= fill_next;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        smooth_reg <= probe;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(WINDOW - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if (track_reg) begin
                            lvl_reg <= upd.nxt;
                        end
                        m_data_reg.level          <= track_reg ? upd.nxt.stable
                                                               : lvl_reg.stable;
                        m_data_reg.smoothed       <= smooth_reg;
                        m_data_reg.rejected       <= rejected_reg;
                        m_data_reg.level_changed  <= track_reg && upd.changed;
                        m_data_reg.rejected_total <= rej_total_reg;
                        m_data_reg.accepted_total <= acc_total_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("window fill count beyond window size");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.mode |=> (fill_reg == '0) && (acc_total_reg == '0))
        else $error("clear beat did not empty the window");

    a_change_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && out_free && track_reg && upd.changed
        |=> lvl_reg.stable != $past(lvl_reg.stable))
        else $error("level change flagged without a new stable level");

endmodule
